### rtl/hcl2_pkg.sv
// Shared constants, types and the angle table of the hyperbolic CORDIC log2 unit.
// Used by hcl2_ctrl, hcl2_datapath and hyperbolic_cordic_log2_unit. No dependencies.
package hcl2_pkg;

    localparam int FRACTION_BITS = 24;
    localparam int ROUNDS        = 24;

    localparam int IN_W       = 28;
    localparam int OUT_W      = 27;
    localparam int TDATA_IN_W = 32;
    localparam int TDATA_OUT_W = 32;
    // x and y stay below 2^30 in magnitude for any 28-bit input.
    localparam int XY_W  = IN_W + 3;
    localparam int Z_W   = 27;
    localparam int IDX_W = 5;

    localparam logic [IDX_W-1:0] REPEAT_A   = IDX_W'(4);
    localparam logic [IDX_W-1:0] REPEAT_B   = IDX_W'(13);
    localparam logic [IDX_W-1:0] LAST_ROUND = IDX_W'(ROUNDS);
    localparam logic [IDX_W-1:0] FIRST_ROUND = IDX_W'(1);

    localparam logic [XY_W-1:0] ONE_XY = XY_W'(1) << FRACTION_BITS;

    // Convergence window 0.1068 .. 9.36 as exact integer bounds on M.
    localparam logic [IN_W-1:0] RANGE_LO = IN_W'(1791807);    // first value in range
    localparam logic [IN_W-1:0] RANGE_HI = IN_W'(157034742);  // first value above range

    typedef struct packed {
        logic             load;
        logic             step;
        logic             store;
        logic [IDX_W-1:0] idx;
    } hcl2_cmd_t;

    typedef struct packed {
        logic out_free;
    } hcl2_stat_t;

    // atanh(2^-i)/ln(2), rounded to nearest with FRACTION_BITS fraction bits.
    function automatic logic [Z_W-1:0] angle_const(input logic [IDX_W-1:0] i);
        logic [Z_W-1:0] a;
        case (i)
            5'd1:    a = Z_W'(13295629);
            5'd2:    a = Z_W'(6182115);
            5'd3:    a = Z_W'(3041458);
            5'd4:    a = Z_W'(1514750);
            5'd5:    a = Z_W'(756634);
            5'd6:    a = Z_W'(378225);
            5'd7:    a = Z_W'(189101);
            5'd8:    a = Z_W'(94549);
            5'd9:    a = Z_W'(47274);
            5'd10:   a = Z_W'(23637);
            5'd11:   a = Z_W'(11819);
            5'd12:   a = Z_W'(5909);
            5'd13:   a = Z_W'(2955);
            5'd14:   a = Z_W'(1477);
            5'd15:   a = Z_W'(739);
            5'd16:   a = Z_W'(369);
            5'd17:   a = Z_W'(185);
            5'd18:   a = Z_W'(92);
            5'd19:   a = Z_W'(46);
            5'd20:   a = Z_W'(23);
            5'd21:   a = Z_W'(12);
            5'd22:   a = Z_W'(6);
            5'd23:   a = Z_W'(3);
            5'd24:   a = Z_W'(1);
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

### rtl/hcl2_ctrl.sv
// Round sequencer of the hyperbolic CORDIC log2 unit: input handshake, round index
// with the repeated rounds, and result hand-off. Depends on hcl2_pkg.
module hcl2_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  hcl2_pkg::hcl2_stat_t stat,
    output hcl2_pkg::hcl2_cmd_t  cmd
);
    import hcl2_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_WAIT = 3'b100
    } state_t;

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             rep_reg, rep_next;
    logic             again;
    logic             last;

    // A repeated round runs once more with the same index before moving on.
    assign again = ((idx_reg == REPEAT_A) || (idx_reg == REPEAT_B)) && !rep_reg;
    assign last  = (idx_reg == LAST_ROUND) && !again;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        rep_next   = rep_reg;
        cmd.load   = 1'b0;
        cmd.step   = 1'b0;
        cmd.store  = 1'b0;
        cmd.idx    = idx_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    idx_next   = FIRST_ROUND;
                    rep_next   = 1'b0;
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                cmd.step = 1'b1;
                if (again) begin
                    rep_next = 1'b1;
                end else begin
                    rep_next = 1'b0;
                    idx_next = idx_reg + IDX_W'(1);
                end
                if (last) begin
                    if (stat.out_free) begin
                        cmd.store  = 1'b1;
                        state_next = ST_IDLE;
                    end else begin
                        state_next = ST_WAIT;
                    end
                end
            end
            ST_WAIT: begin
                if (stat.out_free) begin
                    cmd.store  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            idx_reg   <= FIRST_ROUND;
            rep_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            rep_reg   <= rep_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_load_starts_round_one: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> (state_reg == ST_RUN) && (idx_reg == FIRST_ROUND) && !rep_reg)
        else $error("load did not start at the first round");

    a_idx_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN) |-> (idx_reg >= FIRST_ROUND) && (idx_reg <= LAST_ROUND))
        else $error("round index out of range");

    a_repeat_only_marked: assert property (@(posedge aclk) disable iff (!aresetn)
        rep_reg |-> (idx_reg == REPEAT_A) || (idx_reg == REPEAT_B))
        else $error("repeat flag on a round that is not repeated");

    a_store_needs_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.store |-> stat.out_free && !cmd.load)
        else $error("result stored into an occupied output slot");
`endif

endmodule

### rtl/hcl2_datapath.sv
// Shared shift-add rotator (x, y, z), range check and output register of the
// hyperbolic CORDIC log2 unit. Driven by hcl2_ctrl; depends on hcl2_pkg.
module hcl2_datapath (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  hcl2_pkg::hcl2_cmd_t        cmd,
    output hcl2_pkg::hcl2_stat_t       stat,
    input  logic [hcl2_pkg::IN_W-1:0]  mantissa,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [hcl2_pkg::OUT_W-1:0] log_value,
    output logic                      range_error
);
    import hcl2_pkg::*;

    logic signed [XY_W-1:0] x_reg, y_reg, x_next, y_next, xs, ys, m_ext;
    logic signed [Z_W-1:0]  z_reg, z_next, z_fin, angle;
    logic                   neg;
    logic                   range_reg;
    logic [OUT_W-1:0]       log_reg;
    logic                   err_reg;
    logic                   valid_reg;

    assign m_ext = $signed({{(XY_W-IN_W){1'b0}}, mantissa});
    assign xs    = x_reg >>> cmd.idx;
    assign ys    = y_reg >>> cmd.idx;
    assign neg   = y_reg[XY_W-1];
    assign angle = $signed(angle_const(cmd.idx));

    // Rotate so that y moves toward zero; z collects the angle turned.
    always_comb begin
        if (neg) begin
            x_next = x_reg + ys;
            y_next = y_reg + xs;
            z_next = z_reg - angle;
        end else begin
            x_next = x_reg - ys;
            y_next = y_reg - xs;
            z_next = z_reg + angle;
        end
    end

    assign z_fin = cmd.step ? z_next : z_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            x_reg     <= m_ext + $signed(ONE_XY);
            y_reg     <= m_ext - $signed(ONE_XY);
            z_reg     <= '0;
            range_reg <= (mantissa < RANGE_LO) || (mantissa >= RANGE_HI);
        end else if (cmd.step) begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
        if (cmd.store) begin
            // The vectoring angle is half the logarithm.
            log_reg <= {z_fin[OUT_W-2:0], 1'b0};
            err_reg <= range_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (cmd.store) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    assign stat.out_free = !valid_reg || m_tready;
    assign m_tvalid      = valid_reg;
    assign log_value     = log_reg;
    assign range_error   = err_reg;

endmodule

### rtl/hyperbolic_cordic_log2_unit.sv
// Base-2 logarithm by hyperbolic CORDIC in vectoring mode, one rotator round a cycle.
// An accepted input beat runs rounds 1 to 24, rounds 4 and 13 twice, before its result
// is stored. A new beat is taken only once the previous one is done; s_tready is high
// only while the round sequencer is idle, and a finished result waits in the output
// register without holding the rotator unless the previous result is still stalled.
// Reset (aresetn, synchronous, active low) empties the sequencer and the output slot.
module hyperbolic_cordic_log2_unit (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [hcl2_pkg::TDATA_IN_W-1:0]  s_tdata,   // [27:0] mantissa
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [hcl2_pkg::TDATA_OUT_W-1:0] m_tdata,   // [26:0] log_value
    output logic                            m_tuser    // [0] range_error
);
    import hcl2_pkg::*;

    hcl2_cmd_t        cmd;
    hcl2_stat_t       stat;
    logic [OUT_W-1:0] log_value;

    hcl2_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    hcl2_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .stat        (stat),
        .mantissa    (s_tdata[IN_W-1:0]),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .log_value   (log_value),
        .range_error (m_tuser)
    );

    assign m_tdata = {{(TDATA_OUT_W-OUT_W){1'b0}}, log_value};

endmodule
